@@ design/map_bilinear_lookup_top_defines.svh @@
// ----------------------------------------------------------------------------
// map_bilinear_lookup_top_defines
// assertion macros used by the map lookup top module
// ----------------------------------------------------------------------------
`ifndef MAP_BILINEAR_LOOKUP_TOP_DEFINES_SVH
`define MAP_BILINEAR_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define MBL_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("map lookup assertion failed");

// next-cycle implication
`define MBL_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("map lookup assertion failed");

`endif

@@ design/mbl_pkg.sv @@
// ----------------------------------------------------------------------------
// mbl_pkg
// types, constants and helpers of the bilinear map lookup
// ----------------------------------------------------------------------------
package mbl_pkg;

    localparam int MBL_MAP_COLUMNS = 16;
    localparam int MBL_MAP_ROWS    = 16;
    localparam int MBL_X_W         = 16;
    localparam int MBL_Y_W         = 8;
    localparam int MBL_IDX_W       = 4;
    localparam int MBL_DATA_W      = 16;
    localparam int MBL_CELL_W      = 8;
    localparam int MBL_RES_W       = 9;
    localparam int MBL_MAG_W       = 9;
    localparam int MBL_PROD_W      = MBL_X_W + MBL_MAG_W;

    typedef logic signed [MBL_RES_W-1:0] t_result;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_CELL   = 2'd1,
        FN_XAXIS  = 2'd2,
        FN_YAXIS  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        M_IDLE,
        M_XS,
        M_YS,
        M_CELL,
        M_ISTART,
        M_IWAIT
    } t_main_state;

    typedef enum logic [3:0] {
        SR_IDLE,
        SR_FIRST,
        SR_LAST,
        SR_FWD0,
        SR_FWD,
        SR_BWD0,
        SR_BWD,
        SR_FB0,
        SR_FB1
    } t_srch_state;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } t_ip_state;

    // search status back to the sequencer
    typedef struct packed {
        logic                done;
        logic [MBL_X_W-1:0]  lo_val;
        logic [MBL_X_W-1:0]  hi_val;
    } t_srch_stat;

    // one interpolation request
    typedef struct packed {
        logic               start;
        logic [MBL_X_W-1:0] value;
        logic [MBL_X_W-1:0] in_lo;
        logic [MBL_X_W-1:0] in_hi;
        t_result            out_lo;
        t_result            out_hi;
    } t_ip_req;

    function automatic t_result cell_value(input logic [MBL_CELL_W-1:0] b, input logic sgn);
        t_result v;
        v = sgn ? {b[MBL_CELL_W-1], b} : {1'b0, b};
        return v;
    endfunction

endpackage

@@ design/mbl_search.sv @@
// ----------------------------------------------------------------------------
// mbl_search
// axis interval search, one axis entry read per cycle
// ----------------------------------------------------------------------------
module mbl_search #(
    parameter int MAX_N = mbl_pkg::MBL_MAP_COLUMNS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mbl_pkg::MBL_X_W-1:0]    i_value,
    input  logic [$clog2(MAX_N)-1:0]       i_first,
    input  logic [$clog2(MAX_N):0]         i_count,
    input  logic [mbl_pkg::MBL_X_W-1:0]    i_rdata,
    output logic [$clog2(MAX_N)-1:0]       o_addr,
    output logic [$clog2(MAX_N)-1:0]       o_lo,
    output logic [$clog2(MAX_N)-1:0]       o_hi,
    output mbl_pkg::t_srch_stat            o_stat
);
    import mbl_pkg::*;

    localparam int SW = $clog2(MAX_N);
    localparam int EW = SW + 2;

    t_srch_state        r_state, n_state;
    logic [MBL_X_W-1:0] r_v, n_v;
    logic [SW-1:0]      r_s, n_s;
    logic [SW:0]        r_n, n_n;
    logic [SW-1:0]      r_i, n_i;
    logic [MBL_X_W-1:0] r_held, n_held;
    logic [SW-1:0]      r_lo, n_lo, r_hi, n_hi;
    logic [MBL_X_W-1:0] r_lov, n_lov, r_hiv, n_hiv;
    logic               r_done, n_done;

    logic [SW-1:0] nm1, nm2;
    logic [EW-1:0] n_ext, s_p1, i_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_v    <= n_v;
        r_s    <= n_s;
        r_n    <= n_n;
        r_i    <= n_i;
        r_held <= n_held;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_lov  <= n_lov;
        r_hiv  <= n_hiv;
    end

    always_comb begin
        nm1   = SW'(r_n - 1'b1);
        nm2   = SW'(r_n - 2'd2);
        n_ext = EW'(r_n);
        s_p1  = EW'(r_s) + EW'(1);
        i_p2  = EW'(r_i) + EW'(2);

        n_state = r_state;
        n_v     = r_v;
        n_s     = r_s;
        n_n     = r_n;
        n_i     = r_i;
        n_held  = r_held;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_lov   = r_lov;
        n_hiv   = r_hiv;
        n_done  = 1'b0;
        o_addr  = '0;

        case (r_state)
            SR_IDLE: begin
                if (i_start) begin
                    n_v     = i_value;
                    n_s     = i_first;
                    n_n     = i_count;
                    n_state = SR_FIRST;
                end
            end
            SR_FIRST: begin
                // clamp below the first breakpoint
                if (r_v <= i_rdata) begin
                    n_lo    = '0;
                    n_hi    = '0;
                    n_lov   = i_rdata;
                    n_hiv   = i_rdata;
                    n_done  = 1'b1;
                    n_state = SR_IDLE;
                end else begin
                    o_addr  = nm1;
                    n_state = SR_LAST;
                end
            end
            SR_LAST: begin
                if (r_v >= i_rdata) begin
                    n_lo    = nm1;
                    n_hi    = nm1;
                    n_lov   = i_rdata;
                    n_hiv   = i_rdata;
                    n_done  = 1'b1;
                    n_state = SR_IDLE;
                end else if (s_p1 < n_ext) begin
                    o_addr  = r_s;
                    n_i     = r_s;
                    n_state = SR_FWD0;
                end else if (r_s != '0) begin
                    o_addr  = r_s;
                    n_state = SR_BWD0;
                end else begin
                    o_addr  = nm2;
                    n_state = SR_FB0;
                end
            end
            SR_FWD0: begin
                n_held  = i_rdata;
                o_addr  = SW'(EW'(r_i) + EW'(1));
                n_state = SR_FWD;
            end
            SR_FWD: begin
                // i_rdata is entry i+1, r_held is entry i
                if (r_v >= r_held && r_v < i_rdata) begin
                    n_lo    = r_i;
                    n_hi    = SW'(EW'(r_i) + EW'(1));
                    n_lov   = r_held;
                    n_hiv   = i_rdata;
                    n_done  = 1'b1;
                    n_state = SR_IDLE;
                end else begin
                    n_held = i_rdata;
                    n_i    = SW'(EW'(r_i) + EW'(1));
                    if (i_p2 < n_ext) begin
                        o_addr = SW'(i_p2);
                    end else if (r_s != '0) begin
                        o_addr  = r_s;
                        n_state = SR_BWD0;
                    end else begin
                        o_addr  = nm2;
                        n_state = SR_FB0;
                    end
                end
            end
            SR_BWD0: begin
                n_held  = i_rdata;
                n_i     = r_s - 1'b1;
                o_addr  = r_s - 1'b1;
                n_state = SR_BWD;
            end
            SR_BWD: begin
                // i_rdata is entry k, r_held is entry k+1
                if (r_v >= i_rdata && r_v < r_held) begin
                    n_lo    = r_i;
                    n_hi    = SW'(EW'(r_i) + EW'(1));
                    n_lov   = i_rdata;
                    n_hiv   = r_held;
                    n_done  = 1'b1;
                    n_state = SR_IDLE;
                end else begin
                    n_held = i_rdata;
                    if (r_i != '0) begin
                        n_i    = r_i - 1'b1;
                        o_addr = r_i - 1'b1;
                    end else begin
                        o_addr  = nm2;
                        n_state = SR_FB0;
                    end
                end
            end
            SR_FB0: begin
                // no interval matched, take the last one
                n_lov   = i_rdata;
                o_addr  = nm1;
                n_state = SR_FB1;
            end
            SR_FB1: begin
                n_hiv   = i_rdata;
                n_lo    = nm2;
                n_hi    = nm1;
                n_done  = 1'b1;
                n_state = SR_IDLE;
            end
            default: begin
                n_state = SR_IDLE;
            end
        endcase
    end

    assign o_lo          = r_lo;
    assign o_hi          = r_hi;
    assign o_stat.done   = r_done;
    assign o_stat.lo_val = r_lov;
    assign o_stat.hi_val = r_hiv;

endmodule

@@ design/mbl_interp.sv @@
// ----------------------------------------------------------------------------
// mbl_interp
// linear interpolation: one multiply, then a bit-serial restoring divide
// ----------------------------------------------------------------------------
module mbl_interp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbl_pkg::t_ip_req i_req,
    output logic             o_done,
    output mbl_pkg::t_result o_result
);
    import mbl_pkg::*;

    localparam int CW = $clog2(MBL_PROD_W);

    t_ip_state           r_state, n_state;
    logic [MBL_X_W-1:0]  r_dv, n_dv;
    logic [MBL_X_W-1:0]  r_den, n_den;
    logic                r_degen, n_degen;
    logic                r_neg, n_neg;
    logic [MBL_MAG_W-1:0] r_mag, n_mag;
    t_result             r_out_lo, n_out_lo;
    logic [MBL_PROD_W-1:0] r_quo, n_quo;
    logic [MBL_X_W-1:0]  r_rem, n_rem;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_done, n_done;
    t_result             r_result, n_result;

    logic [MBL_X_W-1:0]    vc;
    logic signed [MBL_RES_W:0] dout;
    logic [MBL_X_W:0]      shifted;
    logic [MBL_X_W:0]      diff;
    logic signed [MBL_RES_W:0] q_s;
    logic signed [MBL_RES_W:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_dv     <= n_dv;
        r_den    <= n_den;
        r_degen  <= n_degen;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_out_lo <= n_out_lo;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_dv     = r_dv;
        n_den    = r_den;
        n_degen  = r_degen;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_out_lo = r_out_lo;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_result = r_result;

        if (i_req.value < i_req.in_lo) begin
            vc = i_req.in_lo;
        end else if (i_req.value > i_req.in_hi) begin
            vc = i_req.in_hi;
        end else begin
            vc = i_req.value;
        end
        dout    = (MBL_RES_W+1)'(i_req.out_hi) - (MBL_RES_W+1)'(i_req.out_lo);
        shifted = {r_rem, r_quo[MBL_PROD_W-1]};
        diff    = shifted - {1'b0, r_den};
        q_s     = {1'b0, r_quo[MBL_MAG_W-1:0]};
        sum     = (MBL_RES_W+1)'(r_out_lo) + (r_neg ? -q_s : q_s);

        case (r_state)
            IP_IDLE: begin
                if (i_req.start) begin
                    n_dv     = vc - i_req.in_lo;
                    n_den    = i_req.in_hi - i_req.in_lo;
                    n_degen  = (i_req.in_hi <= i_req.in_lo);
                    n_neg    = dout[MBL_RES_W];
                    n_mag    = MBL_MAG_W'(dout[MBL_RES_W] ? -dout : dout);
                    n_out_lo = i_req.out_lo;
                    n_state  = IP_MUL;
                end
            end
            IP_MUL: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_degen) begin
                    n_quo   = '0;
                    n_state = IP_FIN;
                end else begin
                    n_quo   = MBL_PROD_W'(r_dv) * MBL_PROD_W'(r_mag);
                    n_state = IP_DIV;
                end
            end
            IP_DIV: begin
                // one quotient bit per cycle
                if (!diff[MBL_X_W]) begin
                    n_rem = diff[MBL_X_W-1:0];
                    n_quo = {r_quo[MBL_PROD_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[MBL_X_W-1:0];
                    n_quo = {r_quo[MBL_PROD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(MBL_PROD_W - 1)) begin
                    n_state = IP_FIN;
                end
            end
            IP_FIN: begin
                n_result = sum[MBL_RES_W-1:0];
                n_done   = 1'b1;
                n_state  = IP_IDLE;
            end
            default: begin
                n_state = IP_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ design/map_bilinear_lookup_top.sv @@
// ----------------------------------------------------------------------------
// map_bilinear_lookup_top
// two-dimensional calibration map with bilinear interpolation
// ----------------------------------------------------------------------------
// A write item (cell, X axis or Y axis entry) gives no result. A lookup that
// hits the one-entry cache gives its result the cycle after the transfer. A
// missed lookup runs one axis search per axis in a shared search unit reading
// one breakpoint per cycle; a point that clamps below the first breakpoint or
// above the last ends the search early, else it sweeps forward, then back, and
// falls back to the last interval. It then reads the four corner cells from the
// map memory. Last it uses a shared interpolation unit zero, one or three
// times, each time for one multiply and a bit-serial divide. The block takes
// no new item until the lookup is done; a finished result waits in the output
// register and holds off the next item until it is taken.
module map_bilinear_lookup_top #(
    parameter int MAP_COLUMNS = mbl_pkg::MBL_MAP_COLUMNS,
    parameter int MAP_ROWS    = mbl_pkg::MBL_MAP_ROWS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_func,
    input  logic [mbl_pkg::MBL_X_W-1:0]        i_x_point,
    input  logic [mbl_pkg::MBL_Y_W-1:0]        i_y_point,
    input  logic [mbl_pkg::MBL_IDX_W-1:0]      i_entry_row,
    input  logic [mbl_pkg::MBL_IDX_W-1:0]      i_entry_col,
    input  logic [mbl_pkg::MBL_DATA_W-1:0]     i_entry_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [mbl_pkg::MBL_RES_W-1:0] o_map_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_cells_signed
);
    import mbl_pkg::*;
    `include "map_bilinear_lookup_top_defines.svh"

    localparam int MaxDim = (MAP_COLUMNS > MAP_ROWS) ? MAP_COLUMNS : MAP_ROWS;
    localparam int SW     = $clog2(MaxDim);
    localparam int XAW    = $clog2(MAP_COLUMNS);
    localparam int YAW    = $clog2(MAP_ROWS);
    localparam int CDEPTH = MAP_COLUMNS * MAP_ROWS;
    localparam int CAW    = $clog2(CDEPTH);

    // table memories
    logic [MBL_CELL_W-1:0] r_cmem [CDEPTH];
    logic [MBL_X_W-1:0]    r_xmem [MAP_COLUMNS];
    logic [MBL_Y_W-1:0]    r_ymem [MAP_ROWS];
    logic [MBL_CELL_W-1:0] r_crd;
    logic [MBL_X_W-1:0]    r_xrd;
    logic [MBL_Y_W-1:0]    r_yrd;

    t_main_state        r_state, n_state;
    logic [MBL_X_W-1:0] r_x, n_x;
    logic [MBL_Y_W-1:0] r_y, n_y;
    logic               r_sel, n_sel;
    logic [XAW-1:0]     r_xl, n_xl, r_xh, n_xh;
    logic [YAW-1:0]     r_yl, n_yl, r_yh, n_yh;
    logic [MBL_X_W-1:0] r_xlv, n_xlv, r_xhv, n_xhv;
    logic [MBL_Y_W-1:0] r_ylv, n_ylv, r_yhv, n_yhv;
    t_result            r_q11, n_q11, r_q21, n_q21, r_q12, n_q12, r_q22, n_q22;
    t_result            r_r1, n_r1, r_r2, n_r2;
    logic [2:0]         r_cidx, n_cidx;
    logic [1:0]         r_pass, n_pass;
    logic               r_cvalid, n_cvalid;
    logic [MBL_X_W-1:0] r_cx, n_cx;
    logic [MBL_Y_W-1:0] r_cy, n_cy;
    t_result            r_cres, n_cres;
    logic [XAW-1:0]     r_last_col, n_last_col;
    logic [YAW-1:0]     r_last_row, n_last_row;
    logic               r_cells_signed, n_cells_signed;
    logic               r_ovalid, n_ovalid;
    t_result            r_odata, n_odata;

    logic in_xfer, out_xfer;
    logic cwe, xwe, ywe;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [XAW-1:0] c_col;
    logic [YAW-1:0] c_row;

    logic               s_start;
    logic [MBL_X_W-1:0] s_value;
    logic [SW-1:0]      s_first;
    logic [SW:0]        s_count;
    logic [MBL_X_W-1:0] s_rdata;
    logic [SW-1:0]      s_addr, s_lo, s_hi;
    t_srch_stat         srch_stat;

    t_ip_req ip_req;
    logic    ip_done;
    t_result ip_result;

    logic    x_same, y_same, use_y, last_pass;
    logic    fin;
    t_result fin_val;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_ovalid && !i_stall;
    assign o_stall  = !((r_state == M_IDLE) && (!r_ovalid || !i_stall));
    assign o_valid  = r_ovalid;
    assign o_map_result = r_odata;
    assign o_cfg_ready  = 1'b1;

    // memories
    always_ff @(posedge i_clk) begin
        if (cwe) begin
            r_cmem[c_waddr] <= i_entry_data[MBL_CELL_W-1:0];
        end
        if (xwe) begin
            r_xmem[XAW'(i_entry_col)] <= i_entry_data;
        end
        if (ywe) begin
            r_ymem[YAW'(i_entry_row)] <= i_entry_data[MBL_Y_W-1:0];
        end
        r_crd <= r_cmem[c_raddr];
        r_xrd <= r_xmem[s_addr[XAW-1:0]];
        r_yrd <= r_ymem[s_addr[YAW-1:0]];
    end

    assign c_waddr = CAW'(int'(i_entry_row) * MAP_COLUMNS + int'(i_entry_col));
    assign s_rdata = r_sel ? {{(MBL_X_W-MBL_Y_W){1'b0}}, r_yrd} : r_xrd;

    always_comb begin
        case (r_cidx[1:0])
            2'd0:    begin c_row = r_yl; c_col = r_xl; end
            2'd1:    begin c_row = r_yl; c_col = r_xh; end
            2'd2:    begin c_row = r_yh; c_col = r_xl; end
            default: begin c_row = r_yh; c_col = r_xh; end
        endcase
        c_raddr = CAW'(int'(c_row) * MAP_COLUMNS + int'(c_col));
    end

    mbl_search #(
        .MAX_N (MaxDim)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_value (s_value),
        .i_first (s_first),
        .i_count (s_count),
        .i_rdata (s_rdata),
        .o_addr  (s_addr),
        .o_lo    (s_lo),
        .o_hi    (s_hi),
        .o_stat  (srch_stat)
    );

    mbl_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ip_req),
        .o_done   (ip_done),
        .o_result (ip_result)
    );

    // interpolation operand selection
    always_comb begin
        x_same    = (r_xl == r_xh);
        y_same    = (r_yl == r_yh);
        use_y     = x_same || (r_pass == 2'd2);
        last_pass = x_same || y_same || (r_pass == 2'd2);
        ip_req.start = (r_state == M_ISTART);
        ip_req.value = use_y ? {{(MBL_X_W-MBL_Y_W){1'b0}}, r_y} : r_x;
        ip_req.in_lo = use_y ? {{(MBL_X_W-MBL_Y_W){1'b0}}, r_ylv} : r_xlv;
        ip_req.in_hi = use_y ? {{(MBL_X_W-MBL_Y_W){1'b0}}, r_yhv} : r_xhv;
        if (x_same) begin
            ip_req.out_lo = r_q11;
            ip_req.out_hi = r_q12;
        end else if (y_same || r_pass == 2'd0) begin
            ip_req.out_lo = r_q11;
            ip_req.out_hi = r_q21;
        end else if (r_pass == 2'd1) begin
            ip_req.out_lo = r_q12;
            ip_req.out_hi = r_q22;
        end else begin
            ip_req.out_lo = r_r1;
            ip_req.out_hi = r_r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= M_IDLE;
            r_cvalid       <= 1'b0;
            r_cx           <= '0;
            r_cy           <= '0;
            r_cres         <= '0;
            r_last_col     <= '0;
            r_last_row     <= '0;
            r_cells_signed <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cvalid       <= n_cvalid;
            r_cx           <= n_cx;
            r_cy           <= n_cy;
            r_cres         <= n_cres;
            r_last_col     <= n_last_col;
            r_last_row     <= n_last_row;
            r_cells_signed <= n_cells_signed;
            r_ovalid       <= n_ovalid;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_sel   <= n_sel;
        r_xl    <= n_xl;
        r_xh    <= n_xh;
        r_yl    <= n_yl;
        r_yh    <= n_yh;
        r_xlv   <= n_xlv;
        r_xhv   <= n_xhv;
        r_ylv   <= n_ylv;
        r_yhv   <= n_yhv;
        r_q11   <= n_q11;
        r_q21   <= n_q21;
        r_q12   <= n_q12;
        r_q22   <= n_q22;
        r_r1    <= n_r1;
        r_r2    <= n_r2;
        r_cidx  <= n_cidx;
        r_pass  <= n_pass;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state        = r_state;
        n_x            = r_x;
        n_y            = r_y;
        n_sel          = r_sel;
        n_xl           = r_xl;
        n_xh           = r_xh;
        n_yl           = r_yl;
        n_yh           = r_yh;
        n_xlv          = r_xlv;
        n_xhv          = r_xhv;
        n_ylv          = r_ylv;
        n_yhv          = r_yhv;
        n_q11          = r_q11;
        n_q21          = r_q21;
        n_q12          = r_q12;
        n_q22          = r_q22;
        n_r1           = r_r1;
        n_r2           = r_r2;
        n_cidx         = r_cidx;
        n_pass         = r_pass;
        n_cvalid       = r_cvalid;
        n_cx           = r_cx;
        n_cy           = r_cy;
        n_cres         = r_cres;
        n_last_col     = r_last_col;
        n_last_row     = r_last_row;
        n_cells_signed = r_cells_signed;
        n_ovalid       = out_xfer ? 1'b0 : r_ovalid;
        n_odata        = r_odata;
        cwe            = 1'b0;
        xwe            = 1'b0;
        ywe            = 1'b0;
        s_start        = 1'b0;
        s_value        = {{(MBL_X_W-MBL_Y_W){1'b0}}, r_y};
        s_first        = SW'(r_last_row);
        s_count        = (SW+1)'(MAP_ROWS);
        fin            = 1'b0;
        fin_val        = r_q11;

        case (r_state)
            M_IDLE: begin
                if (in_xfer) begin
                    case (t_func'(i_func))
                        FN_LOOKUP: begin
                            if (r_cvalid && r_cx == i_x_point && r_cy == i_y_point) begin
                                n_ovalid = 1'b1;
                                n_odata  = r_cres;
                            end else begin
                                n_x     = i_x_point;
                                n_y     = i_y_point;
                                n_sel   = 1'b0;
                                s_start = 1'b1;
                                s_value = i_x_point;
                                s_first = SW'(r_last_col);
                                s_count = (SW+1)'(MAP_COLUMNS);
                                n_state = M_XS;
                            end
                        end
                        FN_CELL: begin
                            n_cvalid = 1'b0;
                            cwe = (int'(i_entry_row) < MAP_ROWS)
                                && (int'(i_entry_col) < MAP_COLUMNS);
                        end
                        FN_XAXIS: begin
                            n_cvalid = 1'b0;
                            xwe = (int'(i_entry_col) < MAP_COLUMNS);
                        end
                        FN_YAXIS: begin
                            n_cvalid = 1'b0;
                            ywe = (int'(i_entry_row) < MAP_ROWS);
                        end
                        default: begin
                            n_cvalid = 1'b0;
                        end
                    endcase
                end
            end
            M_XS: begin
                if (srch_stat.done) begin
                    n_xl    = XAW'(s_lo);
                    n_xh    = XAW'(s_hi);
                    n_xlv   = srch_stat.lo_val;
                    n_xhv   = srch_stat.hi_val;
                    n_sel   = 1'b1;
                    s_start = 1'b1;
                    n_state = M_YS;
                end
            end
            M_YS: begin
                if (srch_stat.done) begin
                    n_yl    = YAW'(s_lo);
                    n_yh    = YAW'(s_hi);
                    n_ylv   = srch_stat.lo_val[MBL_Y_W-1:0];
                    n_yhv   = srch_stat.hi_val[MBL_Y_W-1:0];
                    n_cidx  = '0;
                    n_state = M_CELL;
                end
            end
            M_CELL: begin
                // corner read issued at r_cidx, its data lands at r_cidx+1
                n_cidx = r_cidx + 1'b1;
                case (r_cidx)
                    3'd1:    n_q11 = cell_value(r_crd, r_cells_signed);
                    3'd2:    n_q21 = cell_value(r_crd, r_cells_signed);
                    3'd3:    n_q12 = cell_value(r_crd, r_cells_signed);
                    3'd4:    n_q22 = cell_value(r_crd, r_cells_signed);
                    default: n_q11 = r_q11;
                endcase
                if (r_cidx == 3'd4) begin
                    n_pass = '0;
                    if (x_same && y_same) begin
                        fin     = 1'b1;
                        fin_val = r_q11;
                    end else begin
                        n_state = M_ISTART;
                    end
                end
            end
            M_ISTART: begin
                n_state = M_IWAIT;
            end
            M_IWAIT: begin
                if (ip_done) begin
                    if (last_pass) begin
                        fin     = 1'b1;
                        fin_val = ip_result;
                    end else begin
                        if (r_pass == 2'd0) begin
                            n_r1 = ip_result;
                        end else begin
                            n_r2 = ip_result;
                        end
                        n_pass  = r_pass + 1'b1;
                        n_state = M_ISTART;
                    end
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase

        if (fin) begin
            n_ovalid   = 1'b1;
            n_odata    = fin_val;
            n_cvalid   = 1'b1;
            n_cx       = r_x;
            n_cy       = r_y;
            n_cres     = fin_val;
            n_last_col = r_xl;
            n_last_row = r_yl;
            n_state    = M_IDLE;
        end

        if (i_cfg_valid) begin
            n_cells_signed = i_cfg_cells_signed;
            n_cvalid       = 1'b0;
        end
    end

    `MBL_ASSERT_IMP(a_srch_done_in_search, srch_stat.done, r_state == M_XS || r_state == M_YS)
    `MBL_ASSERT_IMP(a_ip_done_in_wait, ip_done, r_state == M_IWAIT)
    `MBL_ASSERT_IMP(a_out_free_while_busy, r_state != M_IDLE, !r_ovalid)
    `MBL_ASSERT_NXT(a_fill_sets_cache, fin && !i_cfg_valid, r_cvalid && r_ovalid)

endmodule
